/* sv/klob_pkg.sv */
package klob_pkg;

	localparam int NSTG = 129;

	localparam logic [31:0] PH_QTR = 32'h4000_0000;
	localparam logic [31:0] POLE_LON = 32'd3472481059;
	localparam logic [55:0] PSI_NUM = 56'd63180098452455214;
	localparam logic [31:0] PSI_REM0 = 32'(PSI_NUM >> 29);
	localparam logic [31:0] PSI_BIAS = 32'd236223201;
	localparam logic signed [30:0] PSI_OFS = 31'sd47244640;
	localparam logic signed [33:0] LAT_LIM = 34'sd893353198;
	localparam logic signed [31:0] OBL_E0 = 32'sd1138166333;
	localparam logic signed [39:0] PER_MIN = 40'sd4718592000;
	localparam logic signed [34:0] X_LIM = 35'sd1685774664;
	localparam logic signed [35:0] NIGHT_PS = 36'sd5120000;
	localparam logic [21:0] DAY16 = 22'd1382400;
	localparam logic signed [22:0] PEAK16 = 23'sd806400;

	localparam logic signed [34:0] S13_C = 35'sd500689;

	typedef struct packed {
		logic signed [31:0] s;
		logic signed [31:0] x2;
		logic signed [34:0] p;
		logic signed [31:0] res;
	} trig_t;

	typedef struct packed {
		logic signed [31:0] lat_u;
		logic signed [31:0] lon_u;
		logic [31:0] az;
		logic [30:0] el;
		logic [23:0] tow;
		trig_t ta;
		trig_t tb;
		logic signed [31:0] d;
		logic signed [31:0] d2;
		logic signed [31:0] d3;
		logic signed [27:0] f24;
		logic [31:0] rem1;
		logic [31:0] den1;
		logic [28:0] q1;
		logic signed [30:0] psi;
		logic signed [33:0] lati;
		logic signed [62:0] nprod;
		logic nneg;
		logic [59:0] nmag;
		logic [30:0] rem2;
		logic [30:0] den2;
		logic [30:0] n2lo;
		logic [30:0] q2;
		logic signed [33:0] loni;
		logic [24:0] u;
		logic [3:0] qe;
		logic [21:0] rr;
		logic signed [20:0] dt;
		logic signed [31:0] phm;
		logic signed [31:0] phm2;
		logic signed [31:0] phm3;
		logic signed [39:0] per_raw;
		logic signed [31:0] amp_raw;
		logic [38:0] per;
		logic [23:0] amp;
		logic dneg;
		logic [38:0] rem3;
		logic [30:0] q3;
		logic [33:0] amp_ps;
		logic signed [31:0] rq;
		logic signed [34:0] x;
		logic night;
		logic [32:0] x2;
		logic [34:0] x4;
		logic [29:0] v3;
		logic signed [33:0] poly;
		logic signed [35:0] inner;
		logic signed [31:0] prod;
		logic [23:0] delay;
	} item_t;

	function automatic logic signed [34:0] horner_c(input int j);
		logic signed [34:0] v;
		case (j)
			0: v = 35'sd7913940;
			1: v = 35'sd88203474;
			2: v = 35'sd643455390;
			3: v = 35'sd2738217788;
			4: v = 35'sd5548789346;
			default: v = 35'sd3373259426;
		endcase
		return v;
	endfunction

	// One step of sin(pi*a) in Q30: reduce, square, six Horner steps, final product.
	function automatic trig_t trig_op(input int j, input trig_t t, input logic [31:0] ph);
		trig_t o;
		logic signed [32:0] s;
		logic signed [69:0] m;
		o = t;
		s = '0;
		m = '0;
		if (j == 0) begin
			s = 33'(signed'(ph));
			if (s > 33'sd1073741824)
				s = 33'sd2147483648 - s;
			else if (s < -33'sd1073741824)
				s = -33'sd2147483648 - s;
			o.s = s[31:0];
		end else if (j == 1) begin
			m = t.s * t.s;
			o.x2 = 32'(m >>> 31);
			o.p = S13_C;
		end else if (j <= 7) begin
			m = t.p * t.x2;
			o.p = 35'(horner_c(j - 2) - (m >>> 31));
		end else begin
			m = t.p * t.s;
			o.res = 32'(m >>> 31);
		end
		return o;
	endfunction

endpackage

/* sv/klobuchar_iono_delay_top.sv */
// Klobuchar ionospheric delay, one query per transfer.
// The input stream carries receiver latitude and longitude, satellite azimuth and
// elevation (semicircles, Q31) and GPS time of week (1/16 s). Each accepted transfer
// yields exactly one output transfer: the slant delay in picoseconds on tdata and the
// night-only flag on tuser.
// The eight broadcast coefficients are written through the configuration port. The user must
// write them only while no query is in flight; the block itself does not enforce this.
// Reset clears them to zero. The datapath is a 130-register pipeline, and a new query can be
// taken in every cycle while the output is not stalled. The three dividers (Earth-centred
// angle, pierce longitude and phase) each resolve one quotient bit per stage, which sets
// the depth.
// Reset clears all valid bits and the coefficient registers.
// When the receiver holds tready low with a result waiting, the whole pipeline
// freezes and s_tready drops in the same cycle; nothing is lost or repeated.
module klobuchar_iono_delay_top
	import klob_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	// user_latitude, user_longitude, sat_azimuth, sat_elevation, gps_time, one pad bit
	input  logic [151:0]       s_tdata,
	output logic               m_tvalid,
	input  logic               m_tready,
	// delay_ps
	output logic [23:0]        m_tdata,
	// night_only
	output logic               m_tuser,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [7:0]         cfg_wdata
);

	localparam int D1_F = 2;
	localparam int D1_L = 30;
	localparam int PSI_K = 31;
	localparam int LAT_K = 32;
	localparam int CLP_K = 33;
	localparam int T2_B = 34;
	localparam int D2_I = 43;
	localparam int D2_F = 44;
	localparam int D2_L = 74;
	localparam int LON_K = 75;
	localparam int T3_B = 76;
	localparam int QE_K = 77;
	localparam int RR_K = 78;
	localparam int DT_K = 79;
	localparam int PHM_K = 85;
	localparam int PHM2_K = 86;
	localparam int PHM3_K = 87;
	localparam int PA_K = 88;
	localparam int CL2_K = 89;
	localparam int D3_F = 90;
	localparam int D3_L = 120;
	localparam int RQ_K = 121;
	localparam int X_K = 122;
	localparam int X2_K = 123;
	localparam int X4_K = 124;
	localparam int V3_K = 125;
	localparam int POLY_K = 126;
	localparam int INN_K = 127;
	localparam int PRD_K = 128;

	logic signed [7:0] coef_q [8];
	item_t pipe_q [NSTG+1];
	logic [NSTG:0] vld_q;
	logic adv;
	item_t in_item;

	function automatic item_t stage_op(input int k, input item_t a,
			input logic signed [7:0] c [8]);
		item_t o;
		logic signed [69:0] m, m2, m3, m4, m5, m6;
		logic [69:0] mu;
		logic [40:0] rd;
		logic qb;
		logic [21:0] rr2;
		logic [20:0] dmag;
		logic signed [34:0] xa;
		o = a;
		m = '0; m2 = '0; m3 = '0; m4 = '0; m5 = '0; m6 = '0;
		mu = '0; rd = '0; qb = 1'b0; rr2 = '0; dmag = '0; xa = '0;

		if (k >= 1 && k <= 9) begin
			o.ta = trig_op(k - 1, a.ta, a.az + PH_QTR);
			o.tb = trig_op(k - 1, a.tb, a.az);
		end
		if (k == 1) begin
			o.den1 = 32'(a.el) + PSI_BIAS;
			o.rem1 = PSI_REM0;
			o.q1 = '0;
			o.d = OBL_E0 - signed'(32'(a.el));
		end
		if (k == 2) begin
			m = a.d * a.d;
			o.d2 = 32'(m >>> 31);
		end
		if (k == 3) begin
			m = a.d2 * a.d;
			o.d3 = 32'(m >>> 31);
		end
		if (k == 4) begin
			m = 70'sd2147483648 + (70'(a.d3) <<< 4);
			o.f24 = 28'(m >>> 7);
		end
		if (k >= D1_F && k <= D1_L) begin
			rd = {8'd0, a.rem1, PSI_NUM[D1_L - k]};
			qb = rd >= 41'(a.den1);
			if (qb)
				rd = rd - 41'(a.den1);
			o.rem1 = rd[31:0];
			o.q1 = {a.q1[27:0], qb};
		end
		if (k == PSI_K)
			o.psi = 31'(signed'({2'b00, a.q1}) - PSI_OFS);
		if (k == LAT_K) begin
			m = a.psi * a.ta.res;
			m2 = a.psi * a.tb.res;
			o.lati = 34'(a.lat_u + (m >>> 30));
			o.nprod = 63'(m2);
		end
		if (k == CLP_K) begin
			if (a.lati > LAT_LIM)
				o.lati = LAT_LIM;
			else if (a.lati < -LAT_LIM)
				o.lati = -LAT_LIM;
			o.nneg = a.nprod[62];
			o.nmag = a.nprod[62] ? 60'(-a.nprod) : 60'(a.nprod);
		end
		if (k >= T2_B && k <= T2_B + 8)
			o.ta = trig_op(k - T2_B, a.ta, 32'(a.lati) + PH_QTR);
		if (k == D2_I) begin
			o.den2 = (a.ta.res < 32'sd1) ? 31'd1 : 31'(a.ta.res);
			o.rem2 = 31'(a.nmag[59:31]);
			o.n2lo = a.nmag[30:0];
			o.q2 = '0;
		end
		if (k >= D2_F && k <= D2_L) begin
			rd = {9'd0, a.rem2, a.n2lo[30]};
			qb = rd >= 41'(a.den2);
			if (qb)
				rd = rd - 41'(a.den2);
			o.rem2 = rd[30:0];
			o.n2lo = {a.n2lo[29:0], 1'b0};
			o.q2 = {a.q2[29:0], qb};
		end
		if (k == LON_K)
			o.loni = a.nneg ? 34'(a.lon_u) - 34'(a.q2) : 34'(a.lon_u) + 34'(a.q2);
		if (k >= T3_B && k <= T3_B + 8)
			o.ta = trig_op(k - T3_B, a.ta, 32'(a.loni) - POLE_LON + PH_QTR);
		if (k == T3_B) begin
			m = a.loni * 70'sd691200;
			o.u = 25'((m >>> 31) + signed'(70'(a.tow)) + 70'sd1382400);
		end
		if (k == QE_K) begin
			mu = 70'(a.u) * 70'd3106;
			o.qe = 4'(mu >> 32);
		end
		if (k == RR_K)
			o.rr = 22'(a.u - 25'(a.qe) * 25'd1382400);
		if (k == DT_K) begin
			rr2 = (a.rr >= DAY16) ? a.rr - DAY16 : a.rr;
			o.dt = 21'(signed'({1'b0, rr2}) - PEAK16);
		end
		if (k == PHM_K) begin
			m = 70'sd137438953 * a.ta.res;
			o.phm = 32'(a.lati + (m >>> 30));
		end
		if (k == PHM2_K) begin
			m = a.phm * a.phm;
			o.phm2 = 32'(m >>> 31);
		end
		if (k == PHM3_K) begin
			m = a.phm2 * a.phm;
			o.phm3 = 32'(m >>> 31);
		end
		if (k == PA_K) begin
			m = c[5] * a.phm;
			m2 = c[6] * a.phm2;
			m3 = c[7] * a.phm3;
			o.per_raw = 40'((70'(c[4]) <<< 27) + (m >>> 1) + (m2 <<< 1) + (m3 <<< 1));
			m4 = c[1] * a.phm;
			m5 = c[2] * a.phm2;
			m6 = c[3] * a.phm3;
			o.amp_raw = 32'((70'(c[0]) <<< 10) + (m4 >>> 18) + (m5 >>> 15) + (m6 >>> 15));
		end
		if (k == CL2_K) begin
			o.per = (a.per_raw < PER_MIN) ? 39'(PER_MIN) : 39'(a.per_raw);
			o.amp = (a.amp_raw < 32'sd0) ? 24'd0 : 24'(a.amp_raw);
			o.dneg = a.dt[20];
			dmag = a.dt[20] ? 21'(-a.dt) : 21'(a.dt);
			o.rem3 = 39'({dmag, 11'd0});
			o.q3 = '0;
		end
		if (k == D3_F) begin
			mu = 70'(a.amp) * 70'd244140625;
			o.amp_ps = 34'(mu >> 18);
		end
		if (k >= D3_F && k <= D3_L) begin
			rd = {1'b0, a.rem3, 1'b0};
			qb = rd >= 41'(a.per);
			if (qb)
				rd = rd - 41'(a.per);
			o.rem3 = rd[38:0];
			o.q3 = {a.q3[29:0], qb};
		end
		if (k == RQ_K)
			o.rq = a.dneg ? -signed'({1'b0, a.q3}) : signed'({1'b0, a.q3});
		if (k == X_K) begin
			m = a.rq * 70'sd3373259426;
			o.x = 35'((m >>> 30) <<< 1);
		end
		if (k == X2_K) begin
			xa = (a.x < 35'sd0) ? -a.x : a.x;
			o.night = xa >= X_LIM;
			m = signed'(a.x[31:0]) * signed'(a.x[31:0]);
			o.x2 = 33'(m >>> 30);
		end
		if (k == X4_K) begin
			mu = 70'(a.x2) * 70'(a.x2);
			o.x4 = 35'(mu >> 30);
		end
		if (k == V3_K) begin
			mu = 70'(a.x4[34:3]) * 70'd2863311531;
			o.v3 = 30'(mu >> 33);
		end
		if (k == POLY_K)
			o.poly = 34'sd1073741824 - signed'(34'(a.x2 >> 1)) + signed'(34'(a.v3));
		if (k == INN_K) begin
			m = signed'(35'(a.amp_ps)) * a.poly;
			o.inner = a.night ? NIGHT_PS : 36'(NIGHT_PS + (m >>> 30));
		end
		if (k == PRD_K) begin
			m = a.inner * a.f24;
			o.prod = 32'(m >>> 34);
		end
		if (k == NSTG) begin
			if (a.prod < 32'sd0)
				o.delay = 24'd0;
			else if (a.prod > 32'sd16777215)
				o.delay = 24'hFF_FFFF;
			else
				o.delay = 24'(a.prod);
		end
		return o;
	endfunction

	assign adv = !vld_q[NSTG] || m_tready;
	assign s_tready = adv;

	always_comb begin
		in_item = '0;
		in_item.lat_u = s_tdata[31:0];
		in_item.lon_u = s_tdata[63:32];
		in_item.az = s_tdata[95:64];
		in_item.el = s_tdata[126:96];
		in_item.tow = s_tdata[150:127];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				coef_q[i] <= '0;
		end else if (cfg_we) begin
			coef_q[cfg_index] <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NSTG-1:0], s_tvalid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			pipe_q[0] <= in_item;
	end

	for (genvar g = 1; g <= NSTG; g++) begin : g_stage
		always_ff @(posedge clk) begin
			if (adv)
				pipe_q[g] <= stage_op(g, pipe_q[g-1], coef_q);
		end
	end

	assign m_tvalid = vld_q[NSTG];
	assign m_tdata = pipe_q[NSTG].delay;
	assign m_tuser = pipe_q[NSTG].night;

endmodule

/* bench/tb_klobuchar_iono_delay_top.sv */
module tb_klobuchar_iono_delay_top;

	typedef enum logic [2:0] {
		R_ALPHA0, R_ALPHA1, R_ALPHA2, R_ALPHA3,
		R_BETA0, R_BETA1, R_BETA2, R_BETA3
	} coef_idx_e;

	localparam int PIPE_DEPTH = 129;
	localparam longint SPI_PI = 64'sd3373259426;
	localparam longint SPI_S3 = 64'sd5548789346;
	localparam longint SPI_S5 = 64'sd2738217788;
	localparam longint SPI_S7 = 64'sd643455390;
	localparam longint SPI_S9 = 64'sd88203474;
	localparam longint SPI_S11 = 64'sd7913940;
	localparam longint SPI_S13 = 64'sd500689;
	localparam longint ONE_Q31 = 64'sd2147483648;
	localparam longint ONE_Q30 = 64'sd1073741824;
	localparam longint ECA_NUM = 64'sd63180098452455214;
	localparam longint ECA_BIAS = 64'sd236223201;
	localparam longint ECA_OFS = 64'sd47244640;
	localparam longint PIERCE_LIM = 64'sd893353198;
	localparam longint MAG_POLE = 64'sd3472481059;
	localparam longint MAG_K = 64'sd137438953;
	localparam longint LT_SCALE = 64'sd691200;
	localparam longint DAY_T16 = 64'sd1382400;
	localparam longint PEAK_T16 = 64'sd806400;
	localparam longint OBL_REF = 64'sd1138166333;
	localparam longint PERIOD_MIN = 64'sd4718592000;
	localparam longint PHASE_LIM = 64'sd1685774664;
	localparam longint NIGHT_Q10 = 64'sd5120000;
	localparam longint PS_SCALE = 64'sd1000000000000;
	localparam longint DELAY_SAT = 64'sd16777215;

	typedef struct {
		logic signed [31:0] lat;
		logic signed [31:0] lon;
		logic [31:0] az;
		logic [30:0] el;
		logic [23:0] tow;
	} query_t;

	typedef struct {
		logic [23:0] delay_ps;
		logic night_only;
	} delay_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [151:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic m_tuser;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [7:0] cfg_wdata = '0;

	longint coef_q[8];
	delay_t delay_exp_q[$];
	int n_fail = 0;
	bit drive_done = 1'b0;

	klobuchar_iono_delay_top i_dut (.*);

	always #5 clk = ~clk;

	function automatic longint floor_shr(longint v, int sh);
		return v >>> sh;
	endfunction

	function automatic longint sin_semi(logic [31:0] ph);
		longint s, x2, p;
		s = longint'(ph);
		if (s >= ONE_Q31) s -= 2 * ONE_Q31;
		if (s > ONE_Q30) s = ONE_Q31 - s;
		else if (s < -ONE_Q30) s = -ONE_Q31 - s;
		x2 = floor_shr(s * s, 31);
		p = SPI_S13;
		p = SPI_S11 - floor_shr(p * x2, 31);
		p = SPI_S9 - floor_shr(p * x2, 31);
		p = SPI_S7 - floor_shr(p * x2, 31);
		p = SPI_S5 - floor_shr(p * x2, 31);
		p = SPI_S3 - floor_shr(p * x2, 31);
		p = SPI_PI - floor_shr(p * x2, 31);
		return floor_shr(p * s, 31);
	endfunction

	function automatic longint cos_semi(logic [31:0] ph);
		return sin_semi(ph + 32'h4000_0000);
	endfunction

	function automatic delay_t iono_delay(query_t q);
		delay_t o;
		longint el, psi, lat_i, lon_i, den, phm, phm2, phm3, t, dt;
		longint d, d2, d3, f24, per, amp, r, x, ax, inner, prod, x2, x4, poly, amp_ps;
		logic night;
		el = longint'(q.el);
		psi = ECA_NUM / (el + ECA_BIAS) - ECA_OFS;
		lat_i = longint'(q.lat) + floor_shr(psi * cos_semi(q.az), 30);
		if (lat_i > PIERCE_LIM) lat_i = PIERCE_LIM;
		else if (lat_i < -PIERCE_LIM) lat_i = -PIERCE_LIM;
		den = cos_semi(lat_i[31:0]);
		if (den < 1) den = 1;
		lon_i = longint'(q.lon) + (psi * sin_semi(q.az)) / den;
		phm = lat_i + floor_shr(MAG_K * cos_semi(32'(lon_i - MAG_POLE)), 30);
		phm2 = floor_shr(phm * phm, 31);
		phm3 = floor_shr(phm2 * phm, 31);
		t = floor_shr(lon_i * LT_SCALE, 31) + longint'(q.tow);
		t %= DAY_T16;
		if (t < 0) t += DAY_T16;
		dt = t - PEAK_T16;
		d = OBL_REF - el;
		d2 = floor_shr(d * d, 31);
		d3 = floor_shr(d2 * d, 31);
		f24 = floor_shr(ONE_Q31 + 16 * d3, 7);
		per = coef_q[R_BETA0] * (64'sd1 << 27) + floor_shr(coef_q[R_BETA1] * phm, 1)
			+ 2 * coef_q[R_BETA2] * phm2 + 2 * coef_q[R_BETA3] * phm3;
		if (per < PERIOD_MIN) per = PERIOD_MIN;
		amp = coef_q[R_ALPHA0] * 1024 + floor_shr(coef_q[R_ALPHA1] * phm, 18)
			+ floor_shr(coef_q[R_ALPHA2] * phm2, 15) + floor_shr(coef_q[R_ALPHA3] * phm3, 15);
		if (amp < 0) amp = 0;
		r = (dt * (64'sd1 << 42)) / per;
		x = 2 * floor_shr(r * SPI_PI, 30);
		ax = x < 0 ? -x : x;
		night = ax >= PHASE_LIM;
		inner = NIGHT_Q10;
		if (!night) begin
			x2 = floor_shr(x * x, 30);
			x4 = floor_shr(x2 * x2, 30);
			poly = ONE_Q30 - floor_shr(x2, 1) + x4 / 24;
			amp_ps = floor_shr(amp * PS_SCALE, 30);
			inner += floor_shr(amp_ps * poly, 30);
		end
		prod = floor_shr(inner * f24, 34);
		if (prod < 0) prod = 0;
		else if (prod > DELAY_SAT) prod = DELAY_SAT;
		o.delay_ps = prod[23:0];
		o.night_only = night;
		return o;
	endfunction

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) < 6) ? 0 : (($urandom_range(0, 19) == 0) ?
			$urandom_range(10, 40) : $urandom_range(1, 3));
		if (n > 0) begin
			s_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send_query(query_t q, bit fixed, delay_t want);
		delay_t e;
		e = fixed ? want : iono_delay(q);
		s_tdata <= {1'b0, q.tow, q.el, q.az, q.lon, q.lat};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		delay_exp_q.insert(delay_exp_q.size(), e);
	endtask

	task automatic write_coef(coef_idx_e idx, logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		coef_q[idx] = longint'(signed'(v));
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (delay_exp_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic query_t rand_query(bit wide);
		query_t q;
		q.lat = wide ? $urandom : 32'($signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
		q.lon = $urandom;
		q.az = $urandom;
		q.el = wide ? 31'($urandom) : 31'($urandom_range(0, 32'h4000_0000));
		q.tow = wide ? 24'($urandom) : 24'($urandom_range(0, 9676799));
		return q;
	endfunction

	always @(posedge clk) begin
		if (drive_done) m_tready <= 1'b1;
		else m_tready <= ($urandom_range(0, 9) < 7) ? 1'b1 : ($urandom_range(0, 29) == 0);
		if (m_tvalid && m_tready) begin
			if (delay_exp_q.size() == 0) begin
				$error("unexpected transfer delay_ps=%0d", m_tdata);
				n_fail++;
			end else begin
				if (m_tdata !== delay_exp_q[0].delay_ps) begin
					$error("delay_ps exp %0d got %0d", delay_exp_q[0].delay_ps, m_tdata);
					n_fail++;
				end
				if (m_tuser !== delay_exp_q[0].night_only) begin
					$error("night_only exp %0d got %0d", delay_exp_q[0].night_only, m_tuser);
					n_fail++;
				end
				void'(delay_exp_q.pop_front());
			end
		end
	end

	initial begin
		query_t q, dir_q[$];
		delay_t dir_e[$];
		bit dir_fixed[$];
		logic [7:0] cv;
		foreach (coef_q[i]) coef_q[i] = 0;
		// Directed rows: extremes of every field, night case, negative F, time wrap.
		q = '{32'sh0, 32'sh0, 32'h0, 31'h0, 24'h0}; dir_q.insert(dir_q.size(), q);
		dir_q.insert(dir_q.size(),
			'{32'shC000_0000, 32'sh8000_0000, 32'hFFFF_FFFF, 31'h4000_0000, 24'd9676799});
		dir_q.insert(dir_q.size(),
			'{32'sh4000_0000, 32'sh7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 24'hFFFFFF});
		dir_q.insert(dir_q.size(),
			'{32'sh7FFF_FFFF, 32'sh4000_0000, 32'h4000_0000, 31'h1000_0000, 24'd806400});
		dir_q.insert(dir_q.size(),
			'{32'sh8000_0000, 32'shC000_0000, 32'hC000_0000, 31'h2000_0000, 24'd1382399});
		dir_q.insert(dir_q.size(),
			'{32'sh1555_5555, 32'shAAAA_AAAA, 32'h5555_5555, 31'h2AAA_AAAA, 24'hAAAAAA});
		dir_q.insert(dir_q.size(),
			'{32'shEAAA_AAAA, 32'sh5555_5555, 32'hAAAA_AAAA, 31'h5555_5555, 24'h555555});
		foreach (dir_q[i]) begin
			dir_fixed.insert(dir_fixed.size(), 1'b0);
			dir_e.insert(dir_e.size(), '{24'd0, 1'b0});
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int ph = 0; ph < 6; ph++) begin
			for (int k = 0; k < 8; k++) begin
				case (ph)
					0: cv = 8'h00;
					1: cv = 8'h7F;
					2: cv = 8'h80;
					default: cv = 8'($urandom);
				endcase
				write_coef(coef_idx_e'(k), cv);
			end
			cfg_we <= 1'b0;
			foreach (dir_q[i]) begin
				send_query(dir_q[i], dir_fixed[i], dir_e[i]);
				idle_gap();
			end
			for (int n = 0; n < 320; n++) begin
				send_query(rand_query($urandom_range(0, 9) == 0), 1'b0, '{24'd0, 1'b0});
				idle_gap();
			end
			drain();
		end
		drive_done = 1'b1;
		drain();
		repeat (PIPE_DEPTH + 20) @(posedge clk);
		if (n_fail == 0 && delay_exp_q.size() == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

	initial begin
		#20000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

/* files.f */
sv/klob_pkg.sv
sv/klobuchar_iono_delay_top.sv
bench/tb_klobuchar_iono_delay_top.sv
